// ===== sv/u8d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 21;
  localparam int unsigned UsedW = 3;
  localparam int unsigned RawW  = 32;
  localparam int unsigned PendW = 24;
  localparam int unsigned CntW  = 2;

  // Lead and continuation masks and patterns
  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContPat   = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Pat  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Pat  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Pat  = 8'hF0;

  // Code point limits
  localparam logic [CodeW-1:0] CodeMax     = 21'h10FFFF;
  localparam logic [CodeW-1:0] SurrogateLo = 21'h00D800;
  localparam logic [CodeW-1:0] SurrogateHi = 21'h00DFFF;
  localparam logic [CodeW-1:0] ReplReset   = 21'h00FFFD;

  // Number of held bytes
  localparam logic [CntW-1:0] CntNone  = 2'd0;
  localparam logic [CntW-1:0] CntOne   = 2'd1;
  localparam logic [CntW-1:0] CntTwo   = 2'd2;
  localparam logic [CntW-1:0] CntThree = 2'd3;

  // Bytes consumed by a result
  localparam logic [UsedW-1:0] UsedOne   = 3'd1;
  localparam logic [UsedW-1:0] UsedTwo   = 3'd2;
  localparam logic [UsedW-1:0] UsedThree = 3'd3;
  localparam logic [UsedW-1:0] UsedFour  = 3'd4;

  // One decoded result
  typedef struct packed {
    logic [CodeW-1:0] code_point;
    logic             is_error;
    logic [UsedW-1:0] bytes_used;
    logic [RawW-1:0]  raw_bytes;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/u8d_byte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_byte_if
// Byte channel: one raw byte and a last-in-buffer flag per beat.
// ----------------------------------------------------------------------------
interface u8d_byte_if;
  logic                           valid;
  logic                           ready;
  logic [u8d_pkg::ByteW-1:0]      data_byte;
  logic                           buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface
`default_nettype wire

// ===== sv/u8d_char_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_char_if
// Character channel: one decoded code point and its status per beat.
// ----------------------------------------------------------------------------
interface u8d_char_if;
  logic                      valid;
  logic                      ready;
  logic [u8d_pkg::CodeW-1:0] code_point;
  logic                      is_error;
  logic [u8d_pkg::UsedW-1:0] bytes_used;
  logic [u8d_pkg::RawW-1:0]  raw_bytes;

  modport source (output valid, output code_point, output is_error,
                  output bytes_used, output raw_bytes, input ready);
  modport sink (input valid, input code_point, input is_error,
                input bytes_used, input raw_bytes, output ready);
endinterface
`default_nettype wire

// ===== sv/utf8_byte_stream_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A result is registered in the result register, or in the skid register while one waits.
// Throughput: one byte per clock while input ready is high; the held-byte state and a
// two-entry output buffer (result register plus skid register) let a byte enter every cycle.
// Input ready is low only while the skid register holds a result.
// Reset: no bytes held, output buffer empty, replacement code 0xFFFD.
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_core
// Lenient UTF-8 decoder: holds up to three bytes of an unfinished sequence
// and gives one result when a character completes or the sequence fails.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [u8d_pkg::CodeW-1:0] cfg_wdata_i,
  u8d_byte_if.sink                       in_if,
  u8d_char_if.source                     out_if
);

  logic [u8d_pkg::CodeW-1:0] repl_q;
  logic [u8d_pkg::PendW-1:0] pend_q, pend_d;
  logic [u8d_pkg::CntW-1:0]  cnt_q, cnt_d;
  u8d_pkg::res_t             out_q, out_d, skid_q, skid_d, res;
  logic                      out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  logic                      accept, out_fire, emit;
  logic [u8d_pkg::ByteW-1:0] b, lead, b2, b3;
  logic [u8d_pkg::RawW-1:0]  raw;
  logic [u8d_pkg::UsedW-1:0] used;
  logic [u8d_pkg::CodeW-1:0] cp2, cp3, cp4;
  logic                      b_cont, cp4_ok;

  assign accept   = in_if.valid & in_if.ready;
  assign out_fire = out_valid_q & out_if.ready;

  // Assemble the current sequence from held bytes and the new byte
  assign b    = in_if.data_byte;
  assign raw  = {pend_q, b};
  assign used = {1'b0, cnt_q} + u8d_pkg::UsedOne;

  always_comb begin
    unique case (cnt_q)
      u8d_pkg::CntNone:  lead = b;
      u8d_pkg::CntOne:   lead = pend_q[7:0];
      u8d_pkg::CntTwo:   lead = pend_q[15:8];
      u8d_pkg::CntThree: lead = pend_q[23:16];
      default:           lead = b;
    endcase
  end

  assign b2 = (cnt_q == u8d_pkg::CntThree) ? pend_q[15:8] : pend_q[7:0];
  assign b3 = pend_q[7:0];

  assign b_cont = (b & u8d_pkg::ContMask) == u8d_pkg::ContPat;
  assign cp2 = {10'd0, lead[4:0], b[5:0]};
  assign cp3 = {5'd0, lead[3:0], b2[5:0], b[5:0]};
  assign cp4 = {lead[2:0], b2[5:0], b3[5:0], b[5:0]};
  assign cp4_ok = ((lead & u8d_pkg::Lead4Mask) == u8d_pkg::Lead4Pat) &&
                  (cp4 <= u8d_pkg::CodeMax) &&
                  ((cp4 < u8d_pkg::SurrogateLo) || (cp4 > u8d_pkg::SurrogateHi));

  // Decide whether this byte ends the sequence and with what result
  always_comb begin
    emit           = 1'b0;
    res.code_point = repl_q;
    res.is_error   = 1'b1;
    res.bytes_used = used;
    res.raw_bytes  = raw;
    priority if (cnt_q == u8d_pkg::CntNone && !b[7]) begin
      emit           = 1'b1;
      res.code_point = {13'd0, b};
      res.is_error   = 1'b0;
    end else if (cnt_q != u8d_pkg::CntNone && !b_cont) begin
      emit = 1'b1;
    end else if (cnt_q == u8d_pkg::CntOne &&
                 (lead & u8d_pkg::Lead2Mask) == u8d_pkg::Lead2Pat) begin
      emit           = 1'b1;
      res.code_point = cp2;
      res.is_error   = 1'b0;
      res.bytes_used = u8d_pkg::UsedTwo;
    end else if (cnt_q == u8d_pkg::CntTwo &&
                 (lead & u8d_pkg::Lead3Mask) == u8d_pkg::Lead3Pat) begin
      emit           = 1'b1;
      res.code_point = cp3;
      res.is_error   = 1'b0;
      res.bytes_used = u8d_pkg::UsedThree;
    end else if (cnt_q == u8d_pkg::CntThree) begin
      emit           = 1'b1;
      res.bytes_used = u8d_pkg::UsedFour;
      if (cp4_ok) begin
        res.code_point = cp4;
        res.is_error   = 1'b0;
      end
    end else if (in_if.buffer_end) begin
      emit = 1'b1;
    end else begin
      emit = 1'b0;
    end
  end

  // Hold unfinished bytes, clear after any result
  always_comb begin
    pend_d = pend_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (emit) begin
        pend_d = '0;
        cnt_d  = u8d_pkg::CntNone;
      end else begin
        pend_d = raw[u8d_pkg::PendW-1:0];
        cnt_d  = used[u8d_pkg::CntW-1:0];
      end
    end
  end

  // Output buffer: result register backed by a skid register
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (accept && emit) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (accept && emit) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  assign in_if.ready = !skid_valid_q;

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q       <= u8d_pkg::ReplReset;
      pend_q       <= '0;
      cnt_q        <= u8d_pkg::CntNone;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        repl_q <= cfg_wdata_i;
      end
      pend_q       <= pend_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.code_point = out_q.code_point;
  assign out_if.is_error   = out_q.is_error;
  assign out_if.bytes_used = out_q.bytes_used;
  assign out_if.raw_bytes  = out_q.raw_bytes;

  // Skid register fills only behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while the result register is empty");

  // A good character never exceeds the code space
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.is_error) |-> (out_q.code_point <= u8d_pkg::CodeMax))
    else $error("decoded code point out of range");

  // Byte count of a result stays in one to four
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.bytes_used != 3'd0 && out_q.bytes_used <= u8d_pkg::UsedFour))
    else $error("bytes_used out of range");

  // Last byte of a buffer always drops the held sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_if.buffer_end) |=> (cnt_q == u8d_pkg::CntNone))
    else $error("bytes held past the end of the buffer");

  // A single-byte good result is plain ASCII
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.is_error && out_q.bytes_used == u8d_pkg::UsedOne)
      |-> (out_q.code_point[u8d_pkg::CodeW-1:7] == '0))
    else $error("one-byte character above 0x7F");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 byte stream decoder. A queue-fed driver
// sends bytes, an in-bench decoder predicts each character, and a monitor
// compares every output beat field by field across several replacement codes.
// ----------------------------------------------------------------------------
module tb;
  import u8d_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseBytes  = 110;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             buffer_end;
  } byte_beat_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CodeW-1:0] cfg_wdata;

  u8d_byte_if byte_ch ();
  u8d_char_if char_ch ();

  utf8_byte_stream_decoder_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_if      (byte_ch),
    .out_if     (char_ch)
  );

  // Bytes waiting to be sent, characters waiting to come out
  byte_beat_t  byte_q[$];
  res_t        char_q[$];

  // Decoder state mirrored by the bench
  logic [PendW-1:0] held_bytes;
  logic [CntW-1:0]  held_count;
  logic [CodeW-1:0] repl_code;

  bit          idle_on;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned cycle_count = 0;
  int unsigned fail_count  = 0;
  int unsigned bytes_in    = 0;
  int unsigned chars_out   = 0;
  int unsigned bad_chars   = 0;
  int unsigned phase_count = 0;
  byte_beat_t  next_beat;
  res_t        char_pred;
  res_t        char_got;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d characters still due", cycle_count,
               char_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // Decode one byte; return 1 and the character when a sequence closes
  function automatic bit decode_byte(input logic [ByteW-1:0] b, input logic buf_end,
                                     output res_t r);
    logic [RawW-1:0]  raw;
    logic [UsedW-1:0] used;
    logic [ByteW-1:0] lead;
    logic [ByteW-1:0] b2;
    logic [ByteW-1:0] b3;
    logic [CodeW-1:0] cp;
    bit               done;
    bit               err;
    raw  = {held_bytes, b};
    used = {1'b0, held_count} + UsedOne;
    lead = b;
    b2   = '0;
    b3   = held_bytes[7:0];
    if (held_count == CntOne) begin
      lead = held_bytes[7:0];
    end else if (held_count == CntTwo) begin
      lead = held_bytes[15:8];
      b2   = held_bytes[7:0];
    end else if (held_count == CntThree) begin
      lead = held_bytes[23:16];
      b2   = held_bytes[15:8];
    end
    done = 1'b0;
    err  = 1'b0;
    cp   = '0;
    if (held_count == CntNone) begin
      if (!b[7]) begin
        done = 1'b1;
        cp   = {13'd0, b};
      end
    end else if ((b & ContMask) != ContPat) begin
      done = 1'b1;
      err  = 1'b1;
    end else if (held_count == CntOne && (lead & Lead2Mask) == Lead2Pat) begin
      done = 1'b1;
      cp   = {10'd0, lead[4:0], b[5:0]};
    end else if (held_count == CntTwo && (lead & Lead3Mask) == Lead3Pat) begin
      done = 1'b1;
      cp   = {5'd0, lead[3:0], b2[5:0], b[5:0]};
    end else if (held_count == CntThree) begin
      done = 1'b1;
      cp   = {lead[2:0], b2[5:0], b3[5:0], b[5:0]};
      // reject bad leads, out-of-range values and surrogates
      err  = (lead & Lead4Mask) != Lead4Pat || cp > CodeMax ||
             (cp >= SurrogateLo && cp <= SurrogateHi);
    end
    if (!done && buf_end) begin
      done = 1'b1;
      err  = 1'b1;
    end
    r = '0;
    if (done) begin
      r.code_point = err ? repl_code : cp;
      r.is_error   = err;
      r.bytes_used = used;
      r.raw_bytes  = raw;
      held_bytes   = '0;
      held_count   = CntNone;
    end else begin
      held_bytes = raw[PendW-1:0];
      held_count = used[CntW-1:0];
    end
    return done;
  endfunction

  task automatic note_fail(input string what, input res_t want, input res_t got_r);
    fail_count++;
    if (fail_count <= ReportLimit) begin
      $display("%0t %s: expected cp=%h err=%b used=%0d raw=%h, got cp=%h err=%b used=%0d raw=%h",
               $realtime, what, want.code_point, want.is_error, want.bytes_used,
               want.raw_bytes, got_r.code_point, got_r.is_error, got_r.bytes_used,
               got_r.raw_bytes);
    end
  endtask

  // Driver: predict on each accepted beat, then present the next byte or idle
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      byte_ch.valid      <= 1'b0;
      byte_ch.data_byte  <= '0;
      byte_ch.buffer_end <= 1'b0;
      send_gap           <= 0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        bytes_in++;
        if (decode_byte(byte_ch.data_byte, byte_ch.buffer_end, char_pred)) begin
          char_q.push_back(char_pred);
        end
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (send_gap > 0) begin
          send_gap      <= send_gap - 1;
          byte_ch.valid <= 1'b0;
        end else if (byte_q.size() > 0 && idle_on && $urandom_range(0, 4) == 0) begin
          send_gap      <= $urandom_range(0, 2);
          byte_ch.valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          next_beat          = byte_q.pop_front();
          byte_ch.valid      <= 1'b1;
          byte_ch.data_byte  <= next_beat.data_byte;
          byte_ch.buffer_end <= next_beat.buffer_end;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each character beat, stall ready in short bursts
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      char_ch.ready <= 1'b0;
      recv_gap      <= 0;
    end else begin
      if (char_ch.valid && char_ch.ready) begin
        char_got.code_point = char_ch.code_point;
        char_got.is_error   = char_ch.is_error;
        char_got.bytes_used = char_ch.bytes_used;
        char_got.raw_bytes  = char_ch.raw_bytes;
        chars_out++;
        if (char_got.is_error === 1'b1) bad_chars++;
        if (char_q.size() == 0) begin
          note_fail("character with none due", '0, char_got);
        end else begin
          char_pred = char_q.pop_front();
          if (char_got.code_point !== char_pred.code_point ||
              char_got.is_error !== char_pred.is_error ||
              char_got.bytes_used !== char_pred.bytes_used ||
              char_got.raw_bytes !== char_pred.raw_bytes) begin
            note_fail("character mismatch", char_pred, char_got);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap      <= recv_gap - 1;
        char_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        recv_gap      <= $urandom_range(0, 2);
        char_ch.ready <= 1'b0;
      end else begin
        char_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void add_byte(input logic [ByteW-1:0] b, input logic buf_end);
    byte_beat_t beat;
    beat.data_byte  = b;
    beat.buffer_end = buf_end;
    byte_q.push_back(beat);
  endfunction

  // Encode a random character of len bytes, first byte in bits 31..24;
  // overlongs and out-of-range four-byte values come out naturally
  function automatic logic [RawW-1:0] encode_char(input int unsigned len);
    logic [CodeW-1:0] cp;
    cp = CodeW'($urandom);
    if (len == 4 && $urandom_range(0, 3) == 0) begin
      cp = CodeW'(SurrogateLo + $urandom_range(0, 'h7FF));
    end
    case (len)
      1:       return {1'b0, cp[6:0], 24'd0};
      2:       return {3'b110, cp[10:6], 2'b10, cp[5:0], 16'd0};
      3:       return {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'd0};
      default: return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                       2'b10, cp[5:0]};
    endcase
  endfunction

  // Mostly well-formed characters; the rest noise, truncation and broken tails
  function automatic void add_random_bytes(input int unsigned count);
    int unsigned      start;
    int unsigned      len;
    int unsigned      cut;
    int unsigned      kind;
    logic [RawW-1:0]  enc;
    logic [ByteW-1:0] junk;
    start = byte_q.size();
    while (byte_q.size() - start < count) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 4);
      enc  = encode_char(len);
      if (kind <= 6) begin
        for (int i = 0; i < len; i++) begin
          add_byte(enc[31-8*i -: 8], $urandom_range(0, 15) == 0);
        end
      end else if (kind == 7) begin
        add_byte(ByteW'($urandom), $urandom_range(0, 3) == 0);
      end else if (kind == 8) begin
        // stop early with the buffer-end flag
        len = $urandom_range(2, 4);
        enc = encode_char(len);
        cut = $urandom_range(1, len - 1);
        for (int i = 0; i < cut; i++) begin
          add_byte(enc[31-8*i -: 8], i == cut - 1);
        end
      end else begin
        // replace one continuation with a byte that is not one
        len = $urandom_range(2, 4);
        enc = encode_char(len);
        cut = $urandom_range(1, len - 1);
        do junk = ByteW'($urandom); while (junk[7:6] == 2'b10);
        for (int i = 0; i < cut; i++) begin
          add_byte(enc[31-8*i -: 8], 1'b0);
        end
        add_byte(junk, 1'b0);
      end
    end
  endfunction

  task automatic wait_drained();
    while (byte_q.size() != 0 || byte_ch.valid || char_q.size() != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_repl(input logic [CodeW-1:0] code);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we    <= 1'b0;
    repl_code = code;
  endtask

  // Sequence the phases
  initial begin
    logic [CodeW-1:0] repl_list[5];
    bit               idle_list[5];
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    byte_ch.valid      = 1'b0;
    byte_ch.data_byte  = '0;
    byte_ch.buffer_end = 1'b0;
    char_ch.ready      = 1'b0;
    held_bytes         = '0;
    held_count         = CntNone;
    repl_code          = ReplReset;
    idle_on            = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes and each special case, reset replacement code
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b1);                                   // ASCII on buffer end
    add_byte(8'hDF, 1'b0); add_byte(8'hBF, 1'b0);            // top two-byte
    add_byte(8'hF4, 1'b0); add_byte(8'h8F, 1'b0);            // top code point
    add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(8'hF4, 1'b0); add_byte(8'h90, 1'b0);            // above range
    add_byte(8'h80, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hF0, 1'b0); add_byte(8'h8D, 1'b0);            // four-byte surrogate
    add_byte(8'hA0, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hC2, 1'b0); add_byte(8'h41, 1'b0);            // bad continuation
    add_byte(8'hFF, 1'b0); add_byte(8'h80, 1'b0);            // bad lead runs four bytes
    add_byte(8'h80, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b0); add_byte(8'h41, 1'b0);            // stray continuation
    add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b1);            // truncated
    add_byte(8'hC2, 1'b1);                                   // lone lead on buffer end
    phase_count++;
    wait_drained();

    // Random phases over several replacement codes; the last one never idles
    repl_list = '{'0, CodeMax, CodeW'($urandom_range(0, CodeMax)),
                  CodeW'($urandom_range(0, CodeMax)), CodeW'($urandom_range(0, CodeMax))};
    idle_list = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    for (int p = 0; p < 5; p++) begin
      write_repl(repl_list[p]);
      idle_on = idle_list[p];
      add_random_bytes(PhaseBytes);
      add_byte(ByteW'($urandom), 1'b1);                      // close any open sequence
      phase_count++;
      wait_drained();
    end

    repeat (5) @(posedge clk);
    while (char_q.size() != 0) note_fail("character never seen", char_q.pop_front(), '0);
    $display("sent %0d bytes in %0d phases, checked %0d characters (%0d flagged bad)",
             bytes_in, phase_count, chars_out, bad_chars);
    $display("%0d mismatches", fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
